// ----- hw/rtl/id3_tag_field_extractor_defines.svh -----
// ----------------------------------------------------------------------------
// ID3 tag field extractor assertion macros
// Concurrent assertion helpers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ID3_TAG_FIELD_EXTRACTOR_DEFINES_SVH
`define ID3_TAG_FIELD_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define ID3_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ID3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/id3_pkg.sv -----
// ----------------------------------------------------------------------------
// ID3 tag field extractor package
// Sizes, character constants and result kind codes.
// ----------------------------------------------------------------------------
package id3_pkg;

   localparam int VALUE_DEPTH = 64;
   localparam int OUT_MAX     = 32;

   localparam int VAL_AW = $clog2(VALUE_DEPTH);
   localparam int IDX_W  = $clog2(OUT_MAX);
   localparam int CNT_W  = $clog2(OUT_MAX + 1);

   typedef logic [7:0]        byte_type;
   typedef logic [6:0]        kept_type;
   typedef logic [VAL_AW-1:0] addr_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [1:0]        kind_type;

   localparam logic [7:0] HEADER_LEN = 8'd10;
   localparam logic [2:0] NAME_MAX   = 3'd5;

   localparam byte_type CH_PRINT_LO = 8'h20;
   localparam byte_type CH_PRINT_HI = 8'h7E;
   localparam byte_type CH_ZERO     = 8'h30;
   localparam byte_type CH_NINE     = 8'h39;
   localparam byte_type CH_OPEN     = 8'h28;
   localparam byte_type CH_CLOSE    = 8'h29;
   localparam byte_type CH_T        = 8'h54;
   localparam byte_type CH_P        = 8'h50;
   localparam byte_type CH_C        = 8'h43;
   localparam byte_type CH_O        = 8'h4F;
   localparam byte_type CH_1        = 8'h31;
   localparam byte_type CH_2        = 8'h32;

   localparam kind_type KIND_TITLE  = 2'd0;
   localparam kind_type KIND_ARTIST = 2'd1;
   localparam kind_type KIND_GENRE  = 2'd2;
   localparam kind_type KIND_CODE   = 2'd3;

   localparam logic [6:0] VALUE_LIMIT_RST = 7'd64;
   localparam logic [6:0] GENRE_CODE_MAX  = 7'd99;

endpackage

// ----- hw/rtl/id3_tag_field_extractor.sv -----
// ----------------------------------------------------------------------------
// ID3 tag field extractor
// Parses ID3 header bytes and emits title, artist and genre characters or genre codes.
// ----------------------------------------------------------------------------
// Parsing takes one byte per cycle except while a run is read back. Kept value
// characters go into a 64 x 8 single-port-write value memory with a registered
// read port. When the last value byte of a title, artist or genre tag arrives,
// the input stalls while the run is read back with one memory read per result;
// output stalls hold the readout. A genre code result is decided from the
// first four kept characters held in registers and takes one slot. Stored
// entries are only read after the current tag wrote them, so the memory needs
// no clearing.
`include "id3_tag_field_extractor_defines.svh"

module id3_tag_field_extractor (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [6:0]           csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output id3_pkg::kind_type    rsp_field_kind,
   output id3_pkg::byte_type    rsp_char_byte,
   output logic [6:0]           rsp_genre_code,
   output logic                 rsp_last_of_run
);
   import id3_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME,
      PH_NAME_END,
      PH_SIZE_OR_ZERO,
      PH_SIZE,
      PH_VALUE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] pcount_ff, pcount_in;
   byte_type   name_ff [3];
   byte_type   name_in [3];
   logic [2:0] nlen_ff, nlen_in;
   kept_type   kept_ff, kept_in;
   logic       skip_ff, skip_in;
   byte_type   head_ff [4];
   byte_type   head_in [4];
   logic [6:0] limit_ff, limit_in;

   logic       busy_ff, busy_in;
   idx_type    idx_ff, idx_in;
   cnt_type    n_ff, n_in;
   kind_type   kind_ff, kind_in;
   logic [6:0] code_ff, code_in;
   logic       cmode_ff, cmode_in;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_last_ff, s1_last_in;
   logic       s1_text_ff, s1_text_in;
   kind_type   s1_kind_ff, s1_kind_in;
   logic [6:0] s1_code_ff, s1_code_in;

   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff, rsp_kind_in;
   byte_type   rsp_char_ff, rsp_char_in;
   logic [6:0] rsp_code_ff, rsp_code_in;
   logic       rsp_last_ff, rsp_last_in;

   byte_type   value_mem [VALUE_DEPTH];
   byte_type   rd_data_ff;
   logic       mem_we;
   addr_type   mem_wa;
   logic       rd_en;

   logic       accept, keep, tag_done, name_ok, go, code_dd, code_d;
   logic       out_free, out_load, issue, issue_last;
   kept_type   kept_end;
   byte_type   head_end [4];
   kind_type   tag_kind;
   logic [7:0] pcount_inc;
   logic [7:0] n_full;

   function automatic logic is_digit(byte_type ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   function automatic logic [3:0] digit_val(byte_type ch);
      byte_type d;
      d = ch - CH_ZERO;
      return d[3:0];
   endfunction

   assign accept     = req_valid && !req_stall;
   assign req_stall  = busy_ff;
   assign pcount_inc = pcount_ff + 8'd1;

   // value byte bookkeeping
   always_comb begin
      keep     = (phase_ff == PH_VALUE) && !skip_ff &&
                 (req_data_byte >= CH_PRINT_LO) && (req_data_byte <= CH_PRINT_HI);
      kept_end = keep ? kept_ff + 7'd1 : kept_ff;
      head_end = head_ff;
      if (keep && (kept_ff < 7'd4)) begin
         head_end[kept_ff[1:0]] = req_data_byte;
      end
      tag_done = accept && (phase_ff == PH_VALUE) && (pcount_ff <= 8'd1);
   end

   // parser
   always_comb begin
      phase_in  = phase_ff;
      pcount_in = pcount_ff;
      name_in   = name_ff;
      nlen_in   = nlen_ff;
      kept_in   = kept_ff;
      skip_in   = skip_ff;
      head_in   = head_ff;
      mem_we    = 1'b0;
      mem_wa    = addr_type'(kept_ff);
      limit_in  = csr_wr_en ? csr_wr_data : limit_ff;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               pcount_in = pcount_inc;
               if (pcount_inc >= HEADER_LEN) begin
                  phase_in = PH_NAME;
                  name_in  = '{default: '0};
                  nlen_in  = '0;
                  kept_in  = '0;
                  skip_in  = 1'b0;
               end
            end
            PH_NAME: begin
               if (req_data_byte == 8'd0) begin
                  phase_in = PH_SIZE_OR_ZERO;
               end else begin
                  if (nlen_ff < 3'd3) begin
                     name_in[nlen_ff[1:0]] = req_data_byte;
                  end
                  nlen_in = nlen_ff + 3'd1;
                  if (nlen_ff + 3'd1 >= NAME_MAX) begin
                     phase_in = PH_NAME_END;
                  end
               end
            end
            PH_NAME_END: begin
               phase_in = PH_SIZE_OR_ZERO;
            end
            PH_SIZE_OR_ZERO, PH_SIZE: begin
               if ((phase_ff == PH_SIZE_OR_ZERO) && (req_data_byte == 8'd0)) begin
                  phase_in = PH_SIZE;
               end else begin
                  kept_in   = '0;
                  skip_in   = req_data_byte > {1'b0, limit_ff};
                  pcount_in = req_data_byte;
                  if (req_data_byte == 8'd0) begin
                     phase_in = PH_NAME;
                     name_in  = '{default: '0};
                     nlen_in  = '0;
                     skip_in  = 1'b0;
                  end else begin
                     phase_in = PH_VALUE;
                  end
               end
            end
            PH_VALUE: begin
               if (keep) begin
                  mem_we = 9'(kept_ff) < 9'(VALUE_DEPTH);
               end
               kept_in   = kept_end;
               head_in   = head_end;
               pcount_in = pcount_ff - 8'd1;
               if (pcount_ff <= 8'd1) begin
                  phase_in = PH_NAME;
                  name_in  = '{default: '0};
                  nlen_in  = '0;
                  kept_in  = '0;
                  skip_in  = 1'b0;
               end
            end
            default: begin
               phase_in  = PH_HEADER;
               pcount_in = '0;
            end
         endcase
         if (req_last_byte) begin
            phase_in  = PH_HEADER;
            pcount_in = '0;
            name_in   = '{default: '0};
            nlen_in   = '0;
            kept_in   = '0;
            skip_in   = 1'b0;
         end
      end
   end

   // end of tag decision
   always_comb begin
      name_ok  = 1'b1;
      tag_kind = KIND_TITLE;
      if ((name_ff[0] == CH_T) && (name_ff[1] == CH_T) && (name_ff[2] == CH_2)) begin
         tag_kind = KIND_TITLE;
      end else if ((name_ff[0] == CH_T) && (name_ff[1] == CH_P) && (name_ff[2] == CH_1)) begin
         tag_kind = KIND_ARTIST;
      end else if ((name_ff[0] == CH_T) && (name_ff[1] == CH_C) && (name_ff[2] == CH_O)) begin
         tag_kind = KIND_GENRE;
      end else begin
         name_ok = 1'b0;
      end
      go = tag_done && !skip_ff && name_ok && (nlen_ff == 3'd3) && (kept_end >= 7'd2);
      code_dd = (tag_kind == KIND_GENRE) && (head_end[0] == CH_OPEN) &&
                is_digit(head_end[1]) && (kept_end >= 7'd4) &&
                is_digit(head_end[2]) && (head_end[3] == CH_CLOSE);
      code_d  = (tag_kind == KIND_GENRE) && (head_end[0] == CH_OPEN) &&
                is_digit(head_end[1]) && (kept_end >= 7'd3) &&
                (head_end[2] == CH_CLOSE);
      n_full  = (8'(kept_end) < 8'(OUT_MAX)) ? 8'(kept_end) : 8'(OUT_MAX);
   end

   // run sequencer and output pipe
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      out_load   = s1_valid_ff && out_free;
      issue      = busy_ff && (!s1_valid_ff || out_load);
      issue_last = (cnt_type'(idx_ff) + cnt_type'(1)) == n_ff;
      rd_en      = issue && !cmode_ff;

      busy_in  = busy_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      kind_in  = kind_ff;
      code_in  = code_ff;
      cmode_in = cmode_ff;
      if (go) begin
         busy_in = 1'b1;
         idx_in  = '0;
         if (code_dd || code_d) begin
            cmode_in = 1'b1;
            n_in     = cnt_type'(1);
            kind_in  = KIND_CODE;
            code_in  = code_dd ? 7'(digit_val(head_end[1])) * 7'd10 +
                                 7'(digit_val(head_end[2]))
                               : 7'(digit_val(head_end[1]));
         end else begin
            cmode_in = 1'b0;
            n_in     = cnt_type'(n_full);
            kind_in  = tag_kind;
            code_in  = '0;
         end
      end else if (issue) begin
         idx_in = idx_ff + idx_type'(1);
         if (issue_last) begin
            busy_in = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      s1_text_in  = s1_text_ff;
      s1_kind_in  = s1_kind_ff;
      s1_code_in  = s1_code_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
         s1_last_in  = issue_last;
         s1_text_in  = !cmode_ff && (9'(idx_ff) < 9'(VALUE_DEPTH));
         s1_kind_in  = kind_ff;
         s1_code_in  = code_ff;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = s1_kind_ff;
         rsp_char_in  = s1_text_ff ? rd_data_ff : 8'd0;
         rsp_code_in  = s1_code_ff;
         rsp_last_in  = s1_last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_mem[mem_wa] <= req_data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= value_mem[addr_type'(idx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pcount_ff    <= '0;
         name_ff      <= '{default: '0};
         nlen_ff      <= '0;
         kept_ff      <= '0;
         skip_ff      <= 1'b0;
         limit_ff     <= VALUE_LIMIT_RST;
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pcount_ff    <= pcount_in;
         name_ff      <= name_in;
         nlen_ff      <= nlen_in;
         kept_ff      <= kept_in;
         skip_ff      <= skip_in;
         limit_ff     <= limit_in;
         busy_ff      <= busy_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff     <= head_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      kind_ff     <= kind_in;
      code_ff     <= code_in;
      cmode_ff    <= cmode_in;
      s1_last_ff  <= s1_last_in;
      s1_text_ff  <= s1_text_in;
      s1_kind_ff  <= s1_kind_in;
      s1_code_ff  <= s1_code_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_kind  = rsp_kind_ff;
   assign rsp_char_byte   = rsp_char_ff;
   assign rsp_genre_code  = rsp_code_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `ID3_ASSERT_NOW(a_code_item_shape, rsp_valid && (rsp_field_kind == KIND_CODE), rsp_last_of_run && (rsp_char_byte == 8'd0) && (rsp_genre_code <= GENRE_CODE_MAX), "genre code item malformed")
   `ID3_ASSERT_NOW(a_text_no_code, rsp_valid && (rsp_field_kind != KIND_CODE), rsp_genre_code == 7'd0, "text item carries a genre code")
   `ID3_ASSERT_NOW(a_idx_in_run, busy_ff, cnt_type'(idx_ff) < n_ff, "run index past run length")
   `ID3_ASSERT_NOW(a_no_write_in_run, mem_we, !busy_ff && !rd_en, "value memory written during run readout")
   `ID3_ASSERT_NEXT(a_last_issue_ends, issue && issue_last, !busy_ff, "run did not end after last read")

endmodule

// ----- test/tb_id3_tag_field_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3 tag field extractor testbench
// Feeds header buffers byte by byte: directed tags for known names, genre
// shapes, name and size corner cases, end of buffer and long runs, then
// random frames under several value limits. A parser model predicts every
// result item, and each received item is compared in order. Both channels
// idle at random, and one long output hold fills up the block.
// ----------------------------------------------------------------------------
module tb_id3_tag_field_extractor;
   import id3_pkg::*;

   localparam int TIMEOUT_NS     = 4_000_000;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 200;
   localparam int RAND_PER_PHASE = 55;

   typedef enum logic [2:0] {
      PH_HEADER, PH_NAME, PH_NAME_END, PH_SIZE_OR_ZERO, PH_SIZE, PH_VALUE
   } parse_phase_e;

   typedef enum int {
      NM_TITLE, NM_ARTIST, NM_GENRE, NM_EMPTY, NM_FIVE, NM_LONG_TT2,
      NM_SHORT_TT, NM_NEAR, NM_RANDOM
   } name_sel_e;

   typedef enum int {
      VS_PRINT, VS_MIXED, VS_RAW, VS_EDGE, VS_CODE1, VS_CODE2
   } value_style_e;

   typedef struct packed {
      kind_type   kind;
      byte_type   ch;
      logic [6:0] code;
      logic       run_end;
   } field_result_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [6:0] csr_wr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   byte_type   req_data_byte = '0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   kind_type   rsp_field_kind;
   byte_type   rsp_char_byte;
   logic [6:0] rsp_genre_code;
   logic       rsp_last_of_run;

   // parser model state
   parse_phase_e ph;
   logic [7:0]   ph_count;
   byte_type     tag_name [NAME_MAX];
   logic [2:0]   tag_name_len;
   byte_type     kept_chars [VALUE_DEPTH];
   kept_type     kept_n;
   logic         skip_value;
   logic [6:0]   limit_reg;

   field_result_t pending_fields [$];
   byte_type      frame_q [$];
   int            errors = 0;
   int            items_sent = 0;
   int            fixed_digit = -1;
   bit            req_idle_en = 1'b1;
   bit            rsp_idle_en = 1'b1;
   logic          hold_on = 1'b0;
   int            stall_left = 0;
   event          hold_go;

   id3_tag_field_extractor i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_kind  (rsp_field_kind),
      .rsp_char_byte   (rsp_char_byte),
      .rsp_genre_code  (rsp_genre_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic byte_type stored_char(input int i);
      if (i < kept_n && i < VALUE_DEPTH) return kept_chars[i];
      return 8'h00;
   endfunction

   function automatic bit is_digit(input byte_type b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic bit name_match(input byte_type a, input byte_type b, input byte_type c);
      return tag_name_len == 3'd3 && tag_name[0] == a && tag_name[1] == b && tag_name[2] == c;
   endfunction

   task automatic start_tag();
      int i;
      for (i = 0; i < NAME_MAX; i++) tag_name[i] = 8'h00;
      tag_name_len = '0;
      kept_n = '0;
      skip_value = 1'b0;
      ph = PH_NAME;
   endtask

   task automatic reset_parser_model();
      int i;
      limit_reg = VALUE_LIMIT_RST;
      ph = PH_HEADER;
      ph_count = '0;
      for (i = 0; i < NAME_MAX; i++) tag_name[i] = 8'h00;
      for (i = 0; i < VALUE_DEPTH; i++) kept_chars[i] = 8'h00;
      tag_name_len = '0;
      kept_n = '0;
      skip_value = 1'b0;
      pending_fields.delete();
   endtask

   task automatic emit_tag_run();
      kind_type      kind;
      field_result_t r;
      int            n;
      int            i;
      int            code_val;
      if (skip_value || kept_n < 2) return;
      if (name_match(CH_T, CH_T, CH_2)) kind = KIND_TITLE;
      else if (name_match(CH_T, CH_P, CH_1)) kind = KIND_ARTIST;
      else if (name_match(CH_T, CH_C, CH_O)) kind = KIND_GENRE;
      else return;
      if (kind == KIND_GENRE && stored_char(0) == CH_OPEN && is_digit(stored_char(1))) begin
         code_val = -1;
         if (is_digit(stored_char(2)) && stored_char(3) == CH_CLOSE)
            code_val = (stored_char(1) - CH_ZERO) * 10 + (stored_char(2) - CH_ZERO);
         else if (stored_char(2) == CH_CLOSE)
            code_val = stored_char(1) - CH_ZERO;
         if (code_val >= 0) begin
            r = {KIND_CODE, 8'h00, code_val[6:0], 1'b1};
            pending_fields.push_back(r);
            return;
         end
      end
      n = (kept_n < OUT_MAX) ? int'(kept_n) : OUT_MAX;
      for (i = 0; i < n; i++) begin
         r = {kind, stored_char(i), 7'd0, (i + 1 == n)};
         pending_fields.push_back(r);
      end
   endtask

   task automatic take_size(input byte_type size);
      kept_n = '0;
      skip_value = size > limit_reg;
      ph_count = size;
      if (size == 8'h00) start_tag();
      else ph = PH_VALUE;
   endtask

   task automatic parse_byte(input byte_type b, input logic eob);
      int i;
      case (ph)
         PH_HEADER: begin
            ph_count = ph_count + 8'd1;
            if (ph_count >= HEADER_LEN) start_tag();
         end
         PH_NAME: begin
            if (b == 8'h00) begin
               ph = PH_SIZE_OR_ZERO;
            end else begin
               if (tag_name_len < NAME_MAX) tag_name[tag_name_len] = b;
               tag_name_len = tag_name_len + 3'd1;
               if (tag_name_len >= NAME_MAX) ph = PH_NAME_END;
            end
         end
         PH_NAME_END: ph = PH_SIZE_OR_ZERO;
         PH_SIZE_OR_ZERO: begin
            if (b == 8'h00) ph = PH_SIZE;
            else take_size(b);
         end
         PH_SIZE: take_size(b);
         PH_VALUE: begin
            if (!skip_value && b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
               if (kept_n < VALUE_DEPTH) kept_chars[kept_n] = b;
               kept_n = kept_n + 7'd1;
            end
            if (ph_count > 0) ph_count = ph_count - 8'd1;
            if (ph_count == 0) begin
               emit_tag_run();
               start_tag();
            end
         end
         default: begin
            ph = PH_HEADER;
            ph_count = '0;
         end
      endcase
      if (eob) begin
         ph = PH_HEADER;
         ph_count = '0;
         for (i = 0; i < NAME_MAX; i++) tag_name[i] = 8'h00;
         tag_name_len = '0;
         kept_n = '0;
         skip_value = 1'b0;
      end
   endtask

   // predict on accepted input items, check accepted result items
   always @(posedge clock) begin : field_check
      field_result_t got;
      field_result_t want;
      if (reset) begin
         reset_parser_model();
      end else begin
         if (csr_wr_en) limit_reg = csr_wr_data;
         if (req_valid && !req_stall) parse_byte(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_field_kind, rsp_char_byte, rsp_genre_code, rsp_last_of_run};
            if (pending_fields.size() == 0) begin
               $display("%0t: unexpected item kind %0d char %h code %0d last %0d",
                        $time, got.kind, got.ch, got.code, got.run_end);
               errors++;
            end else begin
               want = pending_fields.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected kind %0d char %h code %0d last %0d, got kind %0d char %h code %0d last %0d",
                           $time, want.kind, want.ch, want.code, want.run_end,
                           got.kind, got.ch, got.code, got.run_end);
                  errors++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- idling

   function automatic int pick_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin : rsp_side
      logic want_stall;
      want_stall = 1'b0;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         want_stall = 1'b1;
      end else if (rsp_idle_en && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_len() - 1;
         want_stall = 1'b1;
      end
      rsp_stall <= want_stall | hold_on;
   end

   initial begin : output_hold
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_byte(input byte_type b, input logic eob);
      int gap;
      gap = (req_idle_en && $urandom_range(0, 9) < 4) ? pick_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= eob;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_frame(input logic mark_last);
      int i;
      for (i = 0; i < frame_q.size(); i++)
         send_byte(frame_q[i], mark_last && (i == frame_q.size() - 1));
      frame_q.delete();
   endtask

   task automatic cut_frame(input int keep);
      while (frame_q.size() > keep) frame_q.delete(frame_q.size() - 1);
   endtask

   task automatic wait_drained();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      repeat (2) @(posedge clock);
      while (pending_fields.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (pending_fields.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, pending_fields.size());
         errors++;
         pending_fields.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_value_limit(input logic [6:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic byte_type rand_print();
      return CH_PRINT_LO + $urandom_range(0, CH_PRINT_HI - CH_PRINT_LO);
   endfunction

   function automatic byte_type rand_digit();
      return (fixed_digit >= 0) ? CH_ZERO + fixed_digit : CH_ZERO + $urandom_range(0, 9);
   endfunction

   task automatic add_header();
      repeat (HEADER_LEN) frame_q.push_back($urandom_range(0, 255));
   endtask

   task automatic add_tag(input name_sel_e nm, input bit extra_zero, input int size,
                          input value_style_e vs);
      byte_type d1;
      byte_type d2;
      byte_type b;
      int       i;
      d1 = rand_digit();
      d2 = rand_digit();
      case (nm)
         NM_TITLE:    begin frame_q.push_back(CH_T); frame_q.push_back(CH_T); frame_q.push_back(CH_2); end
         NM_ARTIST:   begin frame_q.push_back(CH_T); frame_q.push_back(CH_P); frame_q.push_back(CH_1); end
         NM_GENRE:    begin frame_q.push_back(CH_T); frame_q.push_back(CH_C); frame_q.push_back(CH_O); end
         NM_EMPTY:    ;
         NM_FIVE:     repeat (5) frame_q.push_back($urandom_range(1, 255));
         NM_LONG_TT2: begin
            frame_q.push_back(CH_T); frame_q.push_back(CH_T); frame_q.push_back(CH_2);
            repeat (2) frame_q.push_back($urandom_range(1, 255));
         end
         NM_SHORT_TT: begin frame_q.push_back(CH_T); frame_q.push_back(CH_T); end
         NM_NEAR:     begin
            frame_q.push_back(CH_T); frame_q.push_back(CH_C); frame_q.push_back(CH_O);
            frame_q.push_back($urandom_range(1, 255));
         end
         default:     repeat ($urandom_range(1, 4)) frame_q.push_back($urandom_range(1, 255));
      endcase
      // five-byte names are followed by one byte of any value
      if (nm == NM_FIVE || nm == NM_LONG_TT2) frame_q.push_back($urandom_range(0, 255));
      else frame_q.push_back(8'h00);
      if (extra_zero || size == 0) frame_q.push_back(8'h00);
      frame_q.push_back(size[7:0]);
      for (i = 0; i < size; i++) begin
         b = rand_print();
         case (vs)
            VS_MIXED: if ($urandom_range(0, 1)) b = $urandom_range(0, 255);
            VS_RAW:   b = $urandom_range(0, 255);
            VS_EDGE: begin
               case (i)
                  0: b = CH_PRINT_LO - 8'd1;
                  1: b = CH_PRINT_LO;
                  2: b = CH_PRINT_HI;
                  3: b = CH_PRINT_HI + 8'd1;
                  4: b = 8'h00;
                  5: b = 8'hFF;
                  default: ;
               endcase
            end
            VS_CODE1: begin
               if (i == 0) b = CH_OPEN;
               else if (i == 1) b = d1;
               else if (i == 2) b = CH_CLOSE;
            end
            VS_CODE2: begin
               if (i == 0) b = CH_OPEN;
               else if (i == 1) b = d1;
               else if (i == 2) b = d2;
               else if (i == 3) b = CH_CLOSE;
            end
            default: ;
         endcase
         frame_q.push_back(b);
      end
   endtask

   task automatic add_random_tag();
      name_sel_e    nm;
      value_style_e vs;
      int           r;
      int           size;
      r = $urandom_range(0, 99);
      if (r < 20) nm = NM_TITLE;
      else if (r < 40) nm = NM_ARTIST;
      else if (r < 60) nm = NM_GENRE;
      else if (r < 66) nm = NM_EMPTY;
      else if (r < 74) nm = NM_FIVE;
      else if (r < 80) nm = NM_LONG_TT2;
      else if (r < 86) nm = NM_SHORT_TT;
      else if (r < 92) nm = NM_NEAR;
      else nm = NM_RANDOM;
      r = $urandom_range(0, 99);
      if (r < 75) size = $urandom_range(0, 10);
      else if (r < 92) size = $urandom_range(11, 40);
      else size = $urandom_range(41, 130);
      vs = value_style_e'($urandom_range(0, 5));
      if (nm == NM_GENRE && $urandom_range(0, 1)) vs = $urandom_range(0, 1) ? VS_CODE1 : VS_CODE2;
      add_tag(nm, $urandom_range(0, 1), size, vs);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_known_tags();
      add_header();
      add_tag(NM_TITLE, 1'b0, 3, VS_PRINT);
      add_tag(NM_ARTIST, 1'b1, 2, VS_PRINT);
      add_tag(NM_GENRE, 1'b0, 4, VS_PRINT);
      send_frame(1'b1);
   endtask

   task automatic test_genre_shapes();
      add_header();
      fixed_digit = 9;
      add_tag(NM_GENRE, 1'b0, 4, VS_CODE2);
      fixed_digit = 0;
      add_tag(NM_GENRE, 1'b1, 6, VS_CODE2);
      fixed_digit = -1;
      add_tag(NM_GENRE, 1'b0, 3, VS_CODE1);
      add_tag(NM_GENRE, 1'b0, 5, VS_CODE1);
      add_tag(NM_GENRE, 1'b0, 3, VS_CODE2);
      add_tag(NM_GENRE, 1'b0, 2, VS_CODE1);
      add_tag(NM_TITLE, 1'b0, 4, VS_CODE2);
      send_frame(1'b1);
   endtask

   task automatic test_name_shapes();
      add_header();
      add_tag(NM_EMPTY, 1'b0, 3, VS_PRINT);
      add_tag(NM_FIVE, 1'b0, 3, VS_PRINT);
      add_tag(NM_LONG_TT2, 1'b1, 3, VS_PRINT);
      add_tag(NM_SHORT_TT, 1'b0, 3, VS_PRINT);
      add_tag(NM_NEAR, 1'b0, 3, VS_PRINT);
      add_tag(NM_TITLE, 1'b0, 1, VS_PRINT);
      add_tag(NM_TITLE, 1'b0, 7, VS_EDGE);
      send_frame(1'b1);
   endtask

   task automatic test_size_limits();
      set_value_limit(7'd3);
      add_header();
      add_tag(NM_TITLE, 1'b1, 0, VS_PRINT);
      add_tag(NM_TITLE, 1'b0, 3, VS_PRINT);
      add_tag(NM_TITLE, 1'b0, 4, VS_PRINT);
      send_frame(1'b1);
      set_value_limit(7'd0);
      add_header();
      add_tag(NM_ARTIST, 1'b0, 1, VS_PRINT);
      add_tag(NM_ARTIST, 1'b1, 2, VS_PRINT);
      send_frame(1'b1);
      set_value_limit(VALUE_LIMIT_RST);
   endtask

   task automatic test_long_runs();
      add_header();
      add_tag(NM_TITLE, 1'b0, 40, VS_PRINT);
      add_tag(NM_ARTIST, 1'b0, OUT_MAX, VS_PRINT);
      add_tag(NM_TITLE, 1'b0, 65, VS_PRINT);
      add_tag(NM_GENRE, 1'b0, VALUE_DEPTH, VS_MIXED);
      send_frame(1'b1);
      // limit above the store depth: characters past the store still count
      set_value_limit(7'h7F);
      add_header();
      add_tag(NM_TITLE, 1'b0, 100, VS_PRINT);
      add_tag(NM_ARTIST, 1'b1, 127, VS_PRINT);
      send_frame(1'b1);
      set_value_limit(VALUE_LIMIT_RST);
   endtask

   task automatic test_end_of_buffer();
      add_header();
      add_tag(NM_TITLE, 1'b0, 6, VS_PRINT);
      cut_frame(frame_q.size() - 2);
      send_frame(1'b1);
      add_header();
      add_tag(NM_ARTIST, 1'b1, 4, VS_PRINT);
      send_frame(1'b1);
      add_header();
      add_tag(NM_TITLE, 1'b0, 3, VS_PRINT);
      frame_q.push_back(CH_T);
      send_frame(1'b1);
   endtask

   task automatic test_output_hold();
      wait_drained();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      -> hold_go;
      add_header();
      repeat (3) add_tag(NM_TITLE, 1'b0, 20, VS_PRINT);
      send_frame(1'b1);
      wait_drained();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   task automatic test_random_frames();
      int p;
      int start;
      int r;
      for (p = 0; p < 6; p++) begin
         case (p)
            0: set_value_limit(VALUE_LIMIT_RST);
            1: set_value_limit(7'd0);
            2: set_value_limit(7'h7F);
            3: set_value_limit($urandom_range(1, 63));
            4: set_value_limit(7'd2);
            default: set_value_limit(VALUE_LIMIT_RST);
         endcase
         req_idle_en = (p != 2);
         rsp_idle_en = (p != 2);
         start = items_sent;
         while (items_sent - start < RAND_PER_PHASE) begin
            add_header();
            repeat ($urandom_range(1, 4)) add_random_tag();
            r = $urandom_range(0, 9);
            if (r == 0) cut_frame($urandom_range(1, frame_q.size() - 1));
            else if (r == 1) repeat ($urandom_range(1, 6)) frame_q.push_back($urandom_range(0, 255));
            send_frame(1'b1);
         end
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_known_tags();
      test_genre_shapes();
      test_name_shapes();
      test_size_limits();
      test_long_runs();
      test_end_of_buffer();
      test_output_hold();
      test_random_frames();
      wait_drained();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
